// ===== rtl/gdsc_pkg.sv =====
package gdsc_pkg;

  localparam int unsigned DefMaxYear = 9999;
  localparam int unsigned FirstYear  = 1601;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_SECONDS = 4'd1,
    ST_BEYOND  = 4'd2,
    ST_YEAR    = 4'd3,
    ST_MONTH   = 4'd4,
    ST_DAY     = 4'd5,
    ST_HOUR    = 4'd6,
    ST_MINUTE  = 4'd7,
    ST_SECOND  = 4'd8
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [21:0] day_count;
    logic [16:0] second_of_day;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [21:0] day_count_out;
    logic [16:0] second_of_day_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
  } out_word_t;

  // century index by reciprocal multiply, exact for any 14-bit year
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] p;
    logic [7:0]  c;
    logic [13:0] r;
    p = {13'd0, y} * 27'd5243;
    c = p[26:19];
    r = y - 14'(c) * 14'd100;
    if (y[1:0] != 2'd0) return 1'b0;
    if (r == 14'd0 && c[1:0] != 2'd0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:                                        return leap ? 5'd29 : 5'd28;
      default:                                     return 5'd0;
    endcase
  endfunction

endpackage

// ===== rtl/gregorian_day_second_converter_core.sv =====
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | gdsc_pkg::in_word_t
// out_    | output    | out_valid / out_stall| gdsc_pkg::out_word_t
//
// From acceptance to out_valid, a count-to-date word goes through a shared
// subtract-and-compare unit that peels 400, 100, 4 and 1 year blocks, then
// months, then hours and minutes, one step per cycle. A date-to-count word
// adds months and then 400/100/4/1 year blocks the same way. in_stall is high
// from acceptance until the result is loaded into the output register, and
// while a waiting result is stalled. rst_n clears control only.
// A stalled result holds in the output register; a new word is taken once
// the output register is free or being emptied.
module gregorian_day_second_converter_core #(
  parameter int unsigned MAX_YEAR = gdsc_pkg::DefMaxYear
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdsc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gdsc_pkg::out_word_t out_data
);
  import gdsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_Y400, S_Y100, S_Y4, S_Y1, S_MON, S_SEC, S_DONE
  } state_t;

  state_t      state_r;
  in_word_t    in_r;
  out_word_t   out_r;
  logic        out_valid_r;
  // shared accumulator (days or seconds remaining / total)
  logic [22:0] acc_r;
  logic [13:0] year_r;
  logic [3:0]  mon_r;
  logic [2:0]  cnt_r;
  logic [4:0]  hr_r;
  logic [5:0]  mn_r;
  logic        phase_r;
  // day-of-month remainder saved when leaving the month walk
  logic [22:0] acc_r_day_r;

  // shared unit: one subtract or add with compare
  logic [22:0] step;
  logic [22:0] diff;
  logic        ge;
  logic [22:0] sum;
  logic        leap;
  logic [4:0]  mlen;
  logic [13:0] yrem;
  logic [13:0] ystep;

  assign leap = is_leap(year_r);
  assign mlen = month_len(mon_r, leap);
  assign yrem = in_r.year_in - year_r;

  always_comb begin
    step  = 23'd0;
    ystep = 14'd0;
    unique case (state_r)
      S_Y400: begin step = 23'd146097; ystep = 14'd400; end
      S_Y100: begin step = 23'd36524;  ystep = 14'd100; end
      S_Y4:   begin step = 23'd1461;   ystep = 14'd4;   end
      S_Y1:   begin step = leap ? 23'd366 : 23'd365; ystep = 14'd1; end
      S_MON:  step = 23'(mlen);
      // hours while cnt_r is one, minutes after
      S_SEC:  step = (cnt_r == 3'd1) ? 23'd3600 : 23'd60;
      default: step = 23'd0;
    endcase
  end

  assign diff = acc_r - step;
  assign ge   = acc_r >= step;
  assign sum  = acc_r + step;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [13:0] maxy;
  assign maxy = 14'(MAX_YEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished result, or drop the one just taken
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          in_r    <= in_data;
          out_r   <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          year_r  <= in_r.kind ? in_r.year_in : 14'(FirstYear);
          mon_r   <= 4'd1;
          cnt_r   <= 3'd0;
          phase_r <= 1'b0;
          hr_r    <= 5'd0;
          mn_r    <= 6'd0;
          if (!in_r.kind) begin
            acc_r <= {1'b0, in_r.day_count};
            if (in_r.second_of_day >= 17'd86400) begin
              out_r.status <= ST_SECONDS;
              state_r      <= S_DONE;
            end else state_r <= S_Y400;
          end else begin
            acc_r <= 23'({in_r.day_in} - 6'd1);
            if (in_r.year_in < 14'(FirstYear) || in_r.year_in > maxy) begin
              out_r.status <= ST_YEAR; state_r <= S_DONE;
            end else if (in_r.month_in < 4'd1 || in_r.month_in > 4'd12) begin
              out_r.status <= ST_MONTH; state_r <= S_DONE;
            end else if (in_r.day_in == 5'd0 ||
                         in_r.day_in > month_len(in_r.month_in, is_leap(in_r.year_in))) begin
              out_r.status <= ST_DAY; state_r <= S_DONE;
            end else if (in_r.hour_in > 5'd23) begin
              out_r.status <= ST_HOUR; state_r <= S_DONE;
            end else if (in_r.minute_in > 6'd59) begin
              out_r.status <= ST_MINUTE; state_r <= S_DONE;
            end else if (in_r.second_in > 6'd59) begin
              out_r.status <= ST_SECOND; state_r <= S_DONE;
            end else begin
              // months first (year_r holds the target year), then years
              state_r <= S_MON;
            end
          end
        end
        S_Y400, S_Y100, S_Y4, S_Y1: begin
          if (!in_r.kind) begin
            // peel blocks; 100 and 1 year blocks at most three times
            if (ge && !((state_r == S_Y100 || state_r == S_Y1) && cnt_r == 3'd3)) begin
              acc_r  <= diff;
              year_r <= year_r + ystep;
              cnt_r  <= cnt_r + 3'd1;
            end else begin
              cnt_r <= 3'd0;
              if (state_r == S_Y400) state_r <= S_Y100;
              else if (state_r == S_Y100) state_r <= S_Y4;
              else if (state_r == S_Y4) state_r <= S_Y1;
              else if (year_r > maxy) begin
                out_r.status <= ST_BEYOND; state_r <= S_DONE;
              end else state_r <= S_MON;
            end
          end else begin
            // add whole blocks from 1601 toward the target year
            if (yrem >= ystep) begin
              acc_r  <= sum;
              year_r <= year_r + ystep;
            end else if (state_r == S_Y400) state_r <= S_Y100;
            else if (state_r == S_Y100) state_r <= S_Y4;
            else if (state_r == S_Y4) state_r <= S_Y1;
            else state_r <= S_SEC;
          end
        end
        S_MON: begin
          if (!in_r.kind) begin
            if (mon_r != 4'd12 && ge) begin
              acc_r <= diff; mon_r <= mon_r + 4'd1;
            end else state_r <= S_SEC;
          end else if (mon_r != in_r.month_in) begin
            acc_r <= sum; mon_r <= mon_r + 4'd1;
          end else begin
            year_r  <= 14'(FirstYear);
            state_r <= S_Y400;
          end
        end
        S_SEC: begin
          if (!in_r.kind) begin
            if (!phase_r) begin
              acc_r   <= {6'd0, in_r.second_of_day};
              phase_r <= 1'b1;
              cnt_r   <= 3'd1;
            end else if (cnt_r == 3'd1) begin
              // hours
              if (ge) begin
                acc_r <= diff; hr_r <= hr_r + 5'd1;
              end else cnt_r <= 3'd2;
            end else if (ge) begin
              acc_r <= diff; mn_r <= mn_r + 6'd1;
            end else begin
              out_r.status            <= ST_OK;
              out_r.day_count_out     <= in_r.day_count;
              out_r.second_of_day_out <= in_r.second_of_day;
              out_r.year_out          <= year_r;
              out_r.month_out         <= mon_r;
              out_r.day_out           <= 5'(acc_r_day_r + 23'd1);
              out_r.hour_out          <= hr_r;
              out_r.minute_out        <= mn_r;
              out_r.second_out        <= 6'(acc_r);
              state_r                 <= S_DONE;
            end
          end else begin
            out_r.status            <= ST_OK;
            out_r.day_count_out     <= acc_r[21:0];
            out_r.second_of_day_out <= 17'({12'd0, in_r.second_in} +
                                       17'd60 * {11'd0, in_r.minute_in} +
                                       17'd3600 * {12'd0, in_r.hour_in});
            out_r.year_out          <= in_r.year_in;
            out_r.month_out         <= in_r.month_in;
            out_r.day_out           <= in_r.day_in;
            out_r.hour_out          <= in_r.hour_in;
            out_r.minute_out        <= in_r.minute_in;
            out_r.second_out        <= in_r.second_in;
            state_r                 <= S_DONE;
          end
        end
        S_DONE: if (!out_valid_r || !out_stall) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MON) acc_r_day_r <= acc_r;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.year_out == 14'd0))
    else $error("error result not cleared");

endmodule

// ===== tb/tb_gregorian_day_second_converter_core.sv =====
`timescale 1ns / 100ps

module tb_gregorian_day_second_converter_core;
  import gdsc_pkg::*;

  localparam int unsigned MaxYear = DefMaxYear;
  // day count of 31 December of MaxYear
  localparam int unsigned LastDay = 3067670;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  gregorian_day_second_converter_core #(.MAX_YEAR(MaxYear)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Expected result words, oldest first.
  out_word_t expected_dates[$];
  int        mismatches;
  int        results_seen;
  int        words_sent;
  int        n_kind0;
  int        n_kind1;
  // Receiver hold-off, in cycles; forces the block to back up.
  int        hold_cycles;
  // Receiver wait drawn for each result word.
  int        rx_wait;
  bit        random_stall;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gregorian leap rule.
  function automatic bit leap_year(int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 == 0 && y % 400 != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Work out the result word that one input word must produce.
  function automatic out_word_t convert_date(in_word_t w);
    out_word_t   r;
    int unsigned n, s, yr, q, rem, m, y, mo, d, h, mi, se, yy, nd;
    r = '0;
    if (w.kind == 1'b0) begin
      n = w.day_count;
      s = w.second_of_day;
      if (s >= 86400) begin
        r.status = ST_SECONDS;
        return r;
      end
      yr  = FirstYear + 400 * (n / 146097);
      rem = n % 146097;
      q = rem / 36524;
      if (q > 3) q = 3;
      rem -= q * 36524;
      yr  += 100 * q;
      q = rem / 1461;
      rem -= q * 1461;
      yr  += 4 * q;
      q = rem / 365;
      if (q > 3) q = 3;
      rem -= q * 365;
      yr  += q;
      if (yr > MaxYear) begin
        r.status = ST_BEYOND;
        return r;
      end
      for (m = 1; m < 12; m++) begin
        if (rem < days_of_month(yr, m)) break;
        rem -= days_of_month(yr, m);
      end
      r.status            = ST_OK;
      r.day_count_out     = 22'(n);
      r.second_of_day_out = 17'(s);
      r.year_out          = 14'(yr);
      r.month_out         = 4'(m);
      r.day_out           = 5'(rem + 1);
      r.hour_out          = 5'(s / 3600);
      r.minute_out        = 6'((s % 3600) / 60);
      r.second_out        = 6'(s % 60);
    end else begin
      y  = w.year_in;
      mo = w.month_in;
      d  = w.day_in;
      h  = w.hour_in;
      mi = w.minute_in;
      se = w.second_in;
      if (y < FirstYear || y > MaxYear) r.status = ST_YEAR;
      else if (mo < 1 || mo > 12)       r.status = ST_MONTH;
      else if (d < 1 || d > days_of_month(y, mo)) r.status = ST_DAY;
      else if (h > 23)                  r.status = ST_HOUR;
      else if (mi > 59)                 r.status = ST_MINUTE;
      else if (se > 59)                 r.status = ST_SECOND;
      if (r.status != ST_OK) return r;
      yy = y - FirstYear;
      nd = 0;
      for (m = 1; m < mo; m++) nd += days_of_month(y, m);
      r.day_count_out     = 22'(d - 1 + nd + 365 * yy + yy / 4 - yy / 100 + yy / 400);
      r.second_of_day_out = 17'(se + 60 * (mi + 60 * h));
      r.year_out          = 14'(y);
      r.month_out         = 4'(mo);
      r.day_out           = 5'(d);
      r.hour_out          = 5'(h);
      r.minute_out        = 6'(mi);
      r.second_out        = 6'(se);
    end
    return r;
  endfunction

  // Offer one word after a random gap, hold it until accepted.
  task automatic send_word(in_word_t w, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    in_data  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_dates.push_back(convert_date(w));
    if (w.kind) n_kind1++;
    else n_kind0++;
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_word_t to_date(int unsigned n, int unsigned s);
    in_word_t w;
    w = in_word_t'(80'({$urandom, $urandom, $urandom}));
    w.kind          = 1'b0;
    w.day_count     = 22'(n);
    w.second_of_day = 17'(s);
    return w;
  endfunction

  function automatic in_word_t to_count(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned se);
    in_word_t w;
    w = in_word_t'(80'({$urandom, $urandom, $urandom}));
    w.kind      = 1'b1;
    w.year_in   = 14'(y);
    w.month_in  = 4'(mo);
    w.day_in    = 5'(d);
    w.hour_in   = 5'(h);
    w.minute_in = 6'(mi);
    w.second_in = 6'(se);
    return w;
  endfunction

  // Drain: hold until every expected word has come back.
  task automatic wait_drained();
    while (expected_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Day-count corners: origin, leap-day boundaries, the last legal day and the
  // first day beyond MAX_YEAR, field extremes and the seconds limit.
  task automatic test_day_count_corners();
    send_word(to_date(0, 0));
    send_word(to_date(0, 86399));
    send_word(to_date(0, 86400));
    send_word(to_date(0, 131071));
    send_word(to_date(4194303, 0));
    send_word(to_date(1460, 3600));
    send_word(to_date(146096, 43210));
    send_word(to_date(146097, 59));
    send_word(to_date(36524, 1));
    send_word(to_date(LastDay, 86399));
    send_word(to_date(LastDay + 1, 0));
    send_word(to_date(58, 0));
    send_word(to_date(59 + 365 * 3, 0));
    wait_drained();
  endtask

  // Date corners: every date-side status code, the range ends and February rules.
  task automatic test_date_corners();
    send_word(to_count(1601, 1, 1, 0, 0, 0));
    send_word(to_count(MaxYear, 12, 31, 23, 59, 59));
    send_word(to_count(1600, 1, 1, 0, 0, 0));
    send_word(to_count(MaxYear + 1, 1, 1, 0, 0, 0));
    send_word(to_count(16383, 15, 31, 31, 63, 63));
    send_word(to_count(0, 0, 0, 0, 0, 0));
    send_word(to_count(2000, 0, 1, 0, 0, 0));
    send_word(to_count(2000, 13, 1, 0, 0, 0));
    send_word(to_count(2000, 2, 29, 0, 0, 0));
    send_word(to_count(1900, 2, 29, 0, 0, 0));
    send_word(to_count(2004, 4, 31, 0, 0, 0));
    send_word(to_count(2004, 4, 0, 0, 0, 0));
    send_word(to_count(2004, 4, 30, 24, 0, 0));
    send_word(to_count(2004, 4, 30, 23, 60, 0));
    send_word(to_count(2004, 4, 30, 23, 59, 60));
    wait_drained();
  endtask

  // Mostly legal words with random content; some raw noise for the error paths.
  task automatic test_random(int count);
    in_word_t    w;
    int unsigned y, mo;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_word(to_date($urandom_range(0, LastDay), $urandom_range(0, 86399)));
        3, 4, 5, 6: begin
          y  = ($urandom_range(0, 3) == 0) ? $urandom_range(1601, 2400)
                                            : $urandom_range(1601, MaxYear);
          mo = $urandom_range(1, 12);
          send_word(to_count(y, mo, $urandom_range(1, days_of_month(y, mo)),
                             $urandom_range(0, 23), $urandom_range(0, 59),
                             $urandom_range(0, 59)));
        end
        default: begin
          w = in_word_t'(80'({$urandom, $urandom, $urandom}));
          send_word(w);
        end
      endcase
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // then pause the sender until everything has come back.
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) begin
      send_word(to_date($urandom_range(0, LastDay), $urandom_range(0, 86399)), 1'b0);
    end
    test_random(10);
    wait_drained();
  endtask

  // Receiver: count down any hold-off, then the wait drawn for this word.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      rx_wait      <= random_stall ? int'($urandom_range(0, 15)) : 0;
      if (expected_dates.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %h", out_data);
      end else begin
        want = expected_dates.pop_front();
        if (out_data.status !== want.status ||
            out_data.day_count_out !== want.day_count_out ||
            out_data.second_of_day_out !== want.second_of_day_out ||
            out_data.year_out !== want.year_out ||
            out_data.month_out !== want.month_out ||
            out_data.day_out !== want.day_out ||
            out_data.hour_out !== want.hour_out ||
            out_data.minute_out !== want.minute_out ||
            out_data.second_out !== want.second_out) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    words_sent   = 0;
    n_kind0      = 0;
    n_kind1      = 0;
    hold_cycles  = 0;
    rx_wait      = 0;
    random_stall = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_day_count_corners();
    test_date_corners();
    random_stall = 1'b1;
    test_random(300);
    random_stall = 1'b0;
    test_random(150);
    test_backpressure();
    random_stall = 1'b1;
    test_random(330);
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Sent %0d words (%0d count-to-date, %0d date-to-count), checked %0d results,",
             words_sent, n_kind0, n_kind1, results_seen);
    $display("covering every status code, leap rules and stalls on both sides.");
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout guard for a run of about 830 words, each at its worst case.
  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== gregorian_day_second_converter_core.f =====
rtl/gdsc_pkg.sv
rtl/gregorian_day_second_converter_core.sv
tb/tb_gregorian_day_second_converter_core.sv
